FILE: src/fcur_pkg.sv
// Package: shared types and constants of the four-channel ultrasonic ranger.
package fcur_pkg;
	localparam int CNT_W = 25;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] RANGE_RESET = 25'd116000;
	localparam logic [15:0] HOLD_RESET = 16'd1000;
	localparam logic [7:0] VERSION_BYTE = 8'h01;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TRIG = 3'd1;
	localparam logic [2:0] ST_WAIT = 3'd2;
	localparam logic [2:0] ST_ECHO = 3'd3;
	localparam logic [2:0] ST_HOLD = 3'd4;

	localparam logic [1:0] MD_IDLE = 2'd0;
	localparam logic [1:0] MD_ONE = 2'd1;
	localparam logic [1:0] MD_SYNC = 2'd2;
	localparam logic [1:0] MD_ASYNC = 2'd3;

	localparam logic [7:0] ADDR_RANGE = 8'hA0;
	localparam logic [7:0] ADDR_HOLD = 8'hA8;
	localparam logic [7:0] ADDR_MODE = 8'hB0;
	localparam logic [7:0] ADDR_STATE = 8'hB4;
	localparam logic [7:0] ADDR_VERSION = 8'hC0;

	typedef struct packed {
		logic [1:0] cmd;
		logic [3:0] echo;
		logic [7:0] reg_addr;
		logic [15:0] wdata;
	} item_t;

	typedef struct packed {
		logic [3:0] timed_out;
		logic [3:0] done_res;
		logic [7:0] read_data;
		logic [3:0] trigger;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
	endfunction
endpackage

FILE: src/fcur_chan.sv
// Channel: one sensor's state machine, counters and result register.
module fcur_chan
	import fcur_pkg::*;
#(
	parameter int TRIGGER_TICKS = 50,
	parameter int TICKS_PER_CM = 290
) (
	input  logic clk,
	input  logic arst_n,
	input  logic tick,
	input  logic echo,
	input  logic sync_set,
	input  logic mode_we,
	input  logic [1:0] mode_wd,
	input  logic range_we,
	input  logic [CNT_W-1:0] range_wd,
	input  logic [15:0] hold_ticks,
	output logic [2:0] state,
	output logic [2:0] state_nx,
	output logic [1:0] mode,
	output logic [15:0] range_result,
	output logic [CNT_W-1:0] max_ticks,
	output logic done,
	output logic tmo
);
	localparam int RECIP_W = CNT_W + 11;
	localparam int DIV_W = CNT_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << (CNT_W + 10)) / TICKS_PER_CM + 1);

	logic [2:0] state_q, state_d;
	logic [1:0] mode_q, mode_d;
	logic [CNT_W-1:0] trig_q, trig_d, mark_q, mark_d, trig_i, mark_i, max_q, max_d;
	logic [15:0] res_q, res_d;
	logic sync_q, sync_d;
	logic [CNT_W-1:0] quot;
	logic [DIV_W-1:0] prod;

	// Reciprocal multiply, exact over the full counter range.
	assign prod = DIV_W'(mark_i) * DIV_W'(RECIP);
	assign quot = CNT_W'(prod >> (CNT_W + 10));

	always_comb begin
		trig_i = sat_inc(trig_q);
		mark_i = sat_inc(mark_q);
		state_d = state_q;
		mode_d = mode_q;
		trig_d = trig_q;
		mark_d = mark_q;
		res_d = res_q;
		sync_d = sync_q;
		max_d = max_q;
		done = 1'b0;
		tmo = 1'b0;
		if (tick) begin
			trig_d = trig_i;
			mark_d = mark_i;
			unique case (state_q)
				ST_IDLE: begin
					if (mode_q == MD_ONE || mode_q == MD_ASYNC ||
					    (mode_q == MD_SYNC && sync_q)) begin
						trig_d = '0;
						state_d = ST_TRIG;
						if (mode_q == MD_ONE) mode_d = MD_IDLE;
						if (mode_q == MD_SYNC) sync_d = 1'b0;
					end
				end
				ST_TRIG: begin
					if (trig_i > CNT_W'(TRIGGER_TICKS)) state_d = ST_WAIT;
				end
				ST_WAIT: begin
					if (echo) begin
						mark_d = '0;
						state_d = ST_ECHO;
					end else if (trig_i > max_q) begin
						tmo = 1'b1;
					end
				end
				ST_ECHO: begin
					if (!echo) begin
						res_d = (quot > CNT_W'(16'hFFFF)) ? 16'hFFFF : quot[15:0];
						mark_d = '0;
						state_d = ST_HOLD;
						done = 1'b1;
					end else if (trig_i > max_q) begin
						tmo = 1'b1;
					end
				end
				ST_HOLD: begin
					if (mark_i > CNT_W'(hold_ticks)) state_d = ST_IDLE;
				end
				default: state_d = ST_IDLE;
			endcase
			if (tmo) begin
				res_d = 16'hFFFF;
				mark_d = '0;
				state_d = ST_HOLD;
			end
			if (sync_set) sync_d = 1'b1;
		end
		if (mode_we) mode_d = mode_wd;
		if (range_we) max_d = range_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MD_SYNC;
			trig_q <= '0;
			mark_q <= '0;
			res_q <= '0;
			sync_q <= 1'b0;
			max_q <= RANGE_RESET;
		end else begin
			state_q <= state_d;
			mode_q <= mode_d;
			trig_q <= trig_d;
			mark_q <= mark_d;
			res_q <= res_d;
			sync_q <= sync_d;
			max_q <= max_d;
		end
	end

	assign state = state_q;
	assign state_nx = state_d;
	assign mode = mode_q;
	assign range_result = res_q;
	assign max_ticks = max_q;
endmodule

FILE: src/fcur_regs.sv
// Register read decoder: selects the byte for a read command.
module fcur_regs
	import fcur_pkg::*;
#(
	parameter int NUM_SONARS = 4,
	parameter int TICKS_PER_CM = 290
) (
	input  logic [7:0] reg_addr,
	input  logic [NUM_SONARS-1:0][2:0] state,
	input  logic [NUM_SONARS-1:0][1:0] mode,
	input  logic [NUM_SONARS-1:0][15:0] range_result,
	input  logic [NUM_SONARS-1:0][CNT_W-1:0] max_ticks,
	input  logic [15:0] hold_ticks,
	output logic [7:0] read_data
);
	localparam int RECIP_W = CNT_W + 11;
	localparam int DIV_W = CNT_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << (CNT_W + 10)) / TICKS_PER_CM + 1);

	logic [CNT_W-1:0] mt, quot;
	logic [DIV_W-1:0] prod;
	logic [15:0] v;

	always_comb begin
		mt = '0;
		for (int n = 0; n < NUM_SONARS; n++)
			if (int'(reg_addr[3:1]) == n) mt = max_ticks[n];
	end

	assign prod = DIV_W'(mt) * DIV_W'(RECIP);
	assign quot = CNT_W'(prod >> (CNT_W + 10));

	always_comb begin
		read_data = '0;
		v = '0;
		if (reg_addr <= 8'h07) begin
			for (int n = 0; n < NUM_SONARS; n++)
				if (int'(reg_addr[2:1]) == n) v = range_result[n];
			read_data = reg_addr[0] ? v[15:8] : v[7:0];
		end else if (reg_addr >= ADDR_RANGE && reg_addr < ADDR_HOLD) begin
			v = quot[15:0];
			read_data = reg_addr[0] ? v[15:8] : v[7:0];
		end else if (reg_addr == ADDR_HOLD) begin
			read_data = hold_ticks[7:0];
		end else if (reg_addr == ADDR_HOLD + 8'd1) begin
			read_data = hold_ticks[15:8];
		end else if (reg_addr >= ADDR_MODE && reg_addr < ADDR_STATE) begin
			for (int n = 0; n < NUM_SONARS; n++)
				if (int'(reg_addr[1:0]) == n) read_data = {6'd0, mode[n]};
		end else if (reg_addr >= ADDR_STATE && reg_addr < ADDR_STATE + 8'd4) begin
			for (int n = 0; n < NUM_SONARS; n++)
				if (int'(reg_addr[1:0]) == n) read_data = {5'd0, state[n]};
		end else if (reg_addr == ADDR_VERSION) begin
			read_data = VERSION_BYTE;
		end
	end
endmodule

FILE: src/four_channel_ultrasonic_ranger_top.sv
// Top level: stream ports, shared sync timer, channels and output register.
// Each accepted transfer is one command (timer tick, register write or byte read) and
// yields one result transfer via the input and output registers; a new command is taken
// every cycle while the output side accepts. Channel state updates when the command
// leaves the input register, so the sensor timers advance one step per tick transfer.
module four_channel_ultrasonic_ranger_top
	import fcur_pkg::*;
#(
	parameter int NUM_SONARS = 4,
	parameter int TRIGGER_TICKS = 50,
	parameter int TICKS_PER_CM = 290
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [24:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // cmd, echo, reg_addr, wdata, pad
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [23:0] m_axis_tdata   // trigger, read_data, done_res, timed_out, pad
);
	localparam int LIM = (NUM_SONARS < 4) ? NUM_SONARS : 4;

	item_t it_s1;
	logic v_s1, v_s2, adv;
	result_t res_s2, res_d;
	logic [CNT_W-1:0] period_q, sync_q, sync_i;
	logic [15:0] hold_q;
	logic tick, sync_set;
	logic [NUM_SONARS-1:0][2:0] st;
	logic [NUM_SONARS-1:0][1:0] md;
	logic [NUM_SONARS-1:0][15:0] rr;
	logic [NUM_SONARS-1:0][CNT_W-1:0] mt;
	logic [NUM_SONARS-1:0] dn, tm;
	logic [NUM_SONARS-1:0][2:0] st_n;
	logic [7:0] rd;
	logic [CNT_W+8:0] rng;
	logic [CNT_W-1:0] rng_sat;

	assign adv = !v_s2 || m_axis_tready;
	assign s_axis_tready = adv;
	assign tick = v_s1 && adv && it_s1.cmd == CMD_TICK;
	assign sync_i = sat_inc(sync_q);
	assign sync_set = sync_i >= period_q;
	assign rng = (CNT_W+9)'(it_s1.wdata) * (CNT_W+9)'(TICKS_PER_CM);
	assign rng_sat = (rng > (CNT_W+9)'(CNT_MAX)) ? CNT_MAX : rng[CNT_W-1:0];

	always_ff @(posedge clk) begin
		if (s_axis_tready)
			it_s1 <= {s_axis_tdata[1:0], s_axis_tdata[5:2], s_axis_tdata[13:6],
				s_axis_tdata[29:14]};
		if (adv) res_s2 <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			period_q <= RANGE_RESET;
			sync_q <= '0;
			hold_q <= HOLD_RESET;
		end else begin
			if (adv) begin
				v_s1 <= s_axis_tvalid;
				v_s2 <= v_s1;
			end
			if (cfg_we) period_q <= cfg_wdata;
			if (tick) sync_q <= sync_set ? '0 : sync_i;
			if (v_s1 && adv && it_s1.cmd == CMD_WRITE && it_s1.reg_addr == ADDR_HOLD)
				hold_q <= it_s1.wdata;
		end
	end

	genvar g;
	generate
		for (g = 0; g < NUM_SONARS; g++) begin : g_ch
			fcur_chan #(.TRIGGER_TICKS(TRIGGER_TICKS), .TICKS_PER_CM(TICKS_PER_CM)) u_ch (
				.clk(clk), .arst_n(arst_n), .tick(tick),
				.echo(g < 4 ? it_s1.echo[g % 4] : 1'b0),
				.sync_set(sync_set),
				.mode_we((g < 4) && v_s1 && adv && it_s1.cmd == CMD_WRITE &&
					it_s1.reg_addr == ADDR_MODE + 8'(g)),
				.mode_wd(it_s1.wdata[1:0]),
				.range_we((g < 4) && v_s1 && adv && it_s1.cmd == CMD_WRITE &&
					it_s1.reg_addr == ADDR_RANGE + 8'(2 * g)),
				.range_wd(rng_sat), .hold_ticks(hold_q),
				.state(st[g]), .state_nx(st_n[g]), .mode(md[g]), .range_result(rr[g]),
				.max_ticks(mt[g]), .done(dn[g]), .tmo(tm[g])
			);
		end
	endgenerate

	fcur_regs #(.NUM_SONARS(NUM_SONARS), .TICKS_PER_CM(TICKS_PER_CM)) u_regs (
		.reg_addr(it_s1.reg_addr), .state(st), .mode(md), .range_result(rr),
		.max_ticks(mt), .hold_ticks(hold_q), .read_data(rd)
	);

	always_comb begin
		res_d = '0;
		res_d.trigger = 4'hF;
		for (int n = 0; n < LIM; n++) begin
			res_d.trigger[n] = (st_n[n] != ST_TRIG);
		end
		if (it_s1.cmd == CMD_READ) res_d.read_data = rd;
		if (it_s1.cmd == CMD_TICK) begin
			for (int n = 0; n < LIM; n++) begin
				res_d.done_res[n] = dn[n];
				res_d.timed_out[n] = tm[n];
			end
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata = {4'd0, res_s2};
endmodule

FILE: src/fcur_checker.sv
// Checker: port-level properties of the ranger, bound to the top level.
module fcur_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [23:0] m_axis_tdata
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:20] == 4'd0)
		else $error("pad bits set");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[15:12] & m_axis_tdata[19:16]) == 4'd0)
		else $error("done and timeout on one channel");
endmodule

bind four_channel_ultrasonic_ranger_top fcur_checker u_fcur_checker (.*);

FILE: test/ranger_checker.sv
// Checker: predicts every result of the ranger from its accepted commands and compares.
`timescale 1ns / 100ps
module ranger_checker
	import fcur_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [24:0] cfg_wdata,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	output int pending,
	output int fail_count
);
	localparam int CHANNELS = 4;
	localparam int TRIG_LEN = 50;
	localparam int CM_TICKS = 290;

	logic [2:0] ch_state[CHANNELS];
	logic [1:0] ch_mode[CHANNELS];
	logic [CNT_W-1:0] trig_age[CHANNELS];
	logic [CNT_W-1:0] mark_age[CHANNELS];
	logic [15:0] distance[CHANNELS];
	logic [CNT_W-1:0] limit_ticks[CHANNELS];
	logic sync_req[CHANNELS];
	logic [15:0] hold_len;
	logic [CNT_W-1:0] sync_timer;
	logic [CNT_W-1:0] sync_period;
	result_t pending_results[$];

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [7:0] read_byte(input logic [7:0] a);
		logic [31:0] v;
		if (a <= 8'h07) begin
			v = distance[a[2:1]];
			return a[0] ? v[15:8] : v[7:0];
		end
		if (a >= ADDR_RANGE && a <= ADDR_RANGE + 8'd7) begin
			v = limit_ticks[a[2:1]] / CM_TICKS;
			return a[0] ? v[15:8] : v[7:0];
		end
		if (a == ADDR_HOLD)
			return hold_len[7:0];
		if (a == ADDR_HOLD + 8'd1)
			return hold_len[15:8];
		if (a >= ADDR_MODE && a <= ADDR_MODE + 8'd3)
			return {6'd0, ch_mode[a[1:0]]};
		if (a >= ADDR_STATE && a <= ADDR_STATE + 8'd3)
			return {5'd0, ch_state[a[1:0]]};
		if (a == ADDR_VERSION)
			return VERSION_BYTE;
		return 8'd0;
	endfunction

	function automatic result_t predict(input item_t it);
		result_t r;
		logic [31:0] d;
		logic [63:0] t;
		logic e;
		r = '0;
		if (it.cmd == CMD_TICK) begin
			for (int n = 0; n < CHANNELS; n++) begin
				trig_age[n] = bump(trig_age[n]);
				mark_age[n] = bump(mark_age[n]);
			end
			for (int n = 0; n < CHANNELS; n++) begin
				e = it.echo[n];
				case (ch_state[n])
					ST_IDLE: begin
						if (ch_mode[n] == MD_ONE || ch_mode[n] == MD_ASYNC ||
						    (ch_mode[n] == MD_SYNC && sync_req[n])) begin
							trig_age[n] = '0;
							ch_state[n] = ST_TRIG;
							if (ch_mode[n] == MD_ONE)
								ch_mode[n] = MD_IDLE;
							else if (ch_mode[n] == MD_SYNC)
								sync_req[n] = 1'b0;
						end
					end
					ST_TRIG: begin
						if (trig_age[n] > TRIG_LEN)
							ch_state[n] = ST_WAIT;
					end
					ST_WAIT, ST_ECHO: begin
						if (ch_state[n] == ST_WAIT && e) begin
							mark_age[n] = '0;
							ch_state[n] = ST_ECHO;
						end else if (ch_state[n] == ST_ECHO && !e) begin
							d = mark_age[n] / CM_TICKS;
							distance[n] = (d > 32'hFFFF) ? 16'hFFFF : d[15:0];
							mark_age[n] = '0;
							ch_state[n] = ST_HOLD;
							r.done_res[n] = 1'b1;
						end else if (trig_age[n] > limit_ticks[n]) begin
							distance[n] = 16'hFFFF;
							mark_age[n] = '0;
							ch_state[n] = ST_HOLD;
							r.timed_out[n] = 1'b1;
						end
					end
					ST_HOLD: begin
						if (mark_age[n] > hold_len)
							ch_state[n] = ST_IDLE;
					end
					default: ch_state[n] = ST_IDLE;
				endcase
			end
			sync_timer = bump(sync_timer);
			if (sync_timer >= sync_period) begin
				for (int n = 0; n < CHANNELS; n++)
					sync_req[n] = 1'b1;
				sync_timer = '0;
			end
		end else if (it.cmd == CMD_WRITE) begin
			if (it.reg_addr >= ADDR_MODE && it.reg_addr <= ADDR_MODE + 8'd3) begin
				ch_mode[it.reg_addr[1:0]] = it.wdata[1:0];
			end else if (it.reg_addr >= ADDR_RANGE && it.reg_addr <= ADDR_RANGE + 8'd7 &&
			             !it.reg_addr[0]) begin
				t = 64'(it.wdata) * CM_TICKS;
				limit_ticks[it.reg_addr[2:1]] = (t > CNT_MAX) ? CNT_MAX : t[CNT_W-1:0];
			end else if (it.reg_addr == ADDR_HOLD) begin
				hold_len = it.wdata;
			end
		end else if (it.cmd == CMD_READ) begin
			r.read_data = read_byte(it.reg_addr);
		end
		for (int n = 0; n < CHANNELS; n++)
			r.trigger[n] = (ch_state[n] != ST_TRIG);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_t it;
		result_t want;
		result_t got;
		if (!arst_n) begin
			for (int n = 0; n < CHANNELS; n++) begin
				ch_state[n] = ST_IDLE;
				ch_mode[n] = MD_SYNC;
				trig_age[n] = '0;
				mark_age[n] = '0;
				distance[n] = '0;
				limit_ticks[n] = RANGE_RESET;
				sync_req[n] = 1'b0;
			end
			hold_len = HOLD_RESET;
			sync_timer = '0;
			sync_period = RANGE_RESET;
			pending_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_we)
				sync_period = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				it.cmd = s_axis_tdata[1:0];
				it.echo = s_axis_tdata[5:2];
				it.reg_addr = s_axis_tdata[13:6];
				it.wdata = s_axis_tdata[29:14];
				pending_results.push_back(predict(it));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.trigger = m_axis_tdata[3:0];
				got.read_data = m_axis_tdata[11:4];
				got.done_res = m_axis_tdata[15:12];
				got.timed_out = m_axis_tdata[19:16];
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = pending_results.pop_front();
					if (got.trigger !== want.trigger || got.read_data !== want.read_data ||
					    got.done_res !== want.done_res || got.timed_out !== want.timed_out) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: trigger %h/%h read %h/%h done %h/%h tmo %h/%h",
								want.trigger, got.trigger, want.read_data, got.read_data,
								want.done_res, got.done_res, want.timed_out, got.timed_out);
					end
				end
			end
		end
		pending = pending_results.size();
	end
endmodule

FILE: test/testbench.sv
// Testbench top: clock, reset, command stimulus, output pacing and verdict.
`timescale 1ns / 100ps
module testbench;
	import fcur_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [24:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	int pending;
	int fail_count;
	int cycles = 0;
	logic [3:0] echo_lines = '0;
	int flip_odds = 40;

	always #2 clk = ~clk;

	four_channel_ultrasonic_ranger_top dut (.*);

	ranger_checker checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		int xfers;
		int g;
		xfers = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				xfers++;
			if (xfers == 400) begin
				xfers++;
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			g = gap_len();
			if (g == 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				repeat (g - 1) @(posedge clk);
			end
		end
	end

	task automatic send(input item_t it);
		int g;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, it.wdata, it.reg_addr, it.echo, it.cmd};
		do @(posedge clk); while (!s_axis_tready);
		g = gap_len();
		if (g != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic cmd(input logic [1:0] c, input logic [7:0] a, input logic [15:0] w);
		item_t it;
		it.cmd = c;
		it.echo = echo_lines;
		it.reg_addr = a;
		it.wdata = w;
		send(it);
	endtask

	task automatic drain_and_set(input logic [24:0] period);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= period;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic item_t random_item();
		item_t it;
		int r;
		logic [7:0] mapped[12];
		mapped = '{8'h00, 8'h01, 8'h06, 8'h07, ADDR_RANGE, ADDR_RANGE + 8'd1, ADDR_HOLD,
			ADDR_HOLD + 8'd1, ADDR_MODE, ADDR_STATE + 8'd2, ADDR_VERSION, 8'h08};
		for (int n = 0; n < 4; n++)
			if ($urandom_range(0, flip_odds - 1) == 0)
				echo_lines[n] = ~echo_lines[n];
		if ($urandom_range(0, 199) == 0)
			echo_lines = $urandom_range(0, 15);
		it.echo = echo_lines;
		it.wdata = $urandom_range(0, 65535);
		it.reg_addr = $urandom_range(0, 255);
		r = $urandom_range(0, 99);
		if (r < 80) begin
			it.cmd = CMD_TICK;
		end else if (r < 90) begin
			it.cmd = CMD_WRITE;
			case ($urandom_range(0, 4))
				0, 1: begin
					it.reg_addr = ADDR_MODE + 8'($urandom_range(0, 3));
				end
				2: begin
					it.reg_addr = ADDR_RANGE + 8'(2 * $urandom_range(0, 3));
					if ($urandom_range(0, 7) != 0)
						it.wdata = $urandom_range(1, 4);
				end
				3: begin
					it.reg_addr = ADDR_HOLD;
					if ($urandom_range(0, 7) != 0)
						it.wdata = $urandom_range(0, 20);
				end
				default: ;
			endcase
		end else if (r < 98) begin
			it.cmd = CMD_READ;
			if ($urandom_range(0, 1) == 0)
				it.reg_addr = mapped[$urandom_range(0, 11)];
		end else begin
			it.cmd = 2'd3;
		end
		return it;
	endfunction

	initial begin
		logic [24:0] periods[5];
		periods = '{25'd1, 25'h1FFFFFF, 25'd200, 25'd116000, 25'd7};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cmd(CMD_READ, ADDR_VERSION, 16'h0000);
		cmd(CMD_READ, ADDR_RANGE, 16'h0000);
		cmd(CMD_READ, ADDR_RANGE + 8'd1, 16'h0000);
		cmd(CMD_READ, ADDR_HOLD + 8'd1, 16'h0000);
		cmd(CMD_READ, ADDR_MODE + 8'd3, 16'h0000);
		cmd(CMD_WRITE, ADDR_RANGE, 16'hFFFF);
		cmd(CMD_READ, ADDR_RANGE + 8'd1, 16'h0000);
		cmd(CMD_WRITE, ADDR_RANGE + 8'd2, 16'h0000);
		cmd(CMD_WRITE, ADDR_HOLD, 16'hFFFF);
		cmd(CMD_READ, ADDR_HOLD + 8'd1, 16'h0000);
		cmd(CMD_WRITE, ADDR_HOLD, 16'h0000);
		cmd(CMD_WRITE, 8'hFF, 16'hFFFF);
		cmd(CMD_READ, 8'hFF, 16'h0000);
		cmd(CMD_WRITE, ADDR_RANGE + 8'd1, 16'h1234);
		cmd(2'd3, 8'h00, 16'h0000);
		cmd(CMD_WRITE, ADDR_MODE, {14'h3FFF, MD_ONE});
		cmd(CMD_WRITE, ADDR_MODE + 8'd1, {14'd0, MD_ASYNC});
		cmd(CMD_WRITE, ADDR_MODE + 8'd2, {14'd0, MD_IDLE});
		cmd(CMD_WRITE, ADDR_MODE + 8'd3, {14'd0, MD_SYNC});
		cmd(CMD_TICK, 8'h00, 16'h0000);
		cmd(CMD_READ, ADDR_STATE, 16'h0000);
		cmd(CMD_READ, ADDR_MODE, 16'h0000);
		for (int n = 0; n < 4; n++)
			cmd(CMD_WRITE, ADDR_RANGE + 8'(2 * n), 16'd2);
		for (int p = 0; p < 5; p++) begin
			drain_and_set(periods[p]);
			flip_odds = $urandom_range(20, 300);
			for (int i = 0; i < 320; i++)
				send(random_item());
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
